// ----- sv/mpi_pkg.sv -----
// Package with shared constants and types of the Mandelbrot pixel iteration unit.
`default_nettype none
package mpi_pkg;
   localparam int unsigned QW = 32;
   localparam int unsigned FRAC_BITS = 28;
   localparam int unsigned ITER_W = 10;
   localparam int unsigned COORD_W = 8;
   localparam int unsigned COLOR_W = 8;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned DEF_IMAGE_WIDTH = 256;
   localparam int unsigned DEF_IMAGE_HEIGHT = 256;
   localparam int unsigned NUM_CELLS = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_REAL_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REAL_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAG_MIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAG_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ITER_LIMIT = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP_MUL,
      ST_MAP_ADD,
      ST_ITER,
      ST_DONE
   } state_type;

   // Data handed from one cell to the next.
   typedef struct packed {
      logic               active;
      logic signed [QW-1:0] zr;
      logic signed [QW-1:0] zi;
      logic [ITER_W-1:0]  count;
   } link_type;

   function automatic logic signed [QW-1:0] sat_q(input logic signed [QW+3:0] v);
      logic signed [QW+3:0] hi;
      logic signed [QW+3:0] lo;
      hi = (QW+4)'(signed'({1'b0, {(QW-1){1'b1}}}));
      lo = -hi - (QW+4)'(1);
      if (v > hi) begin
         return hi[QW-1:0];
      end else if (v < lo) begin
         return lo[QW-1:0];
      end
      return v[QW-1:0];
   endfunction
endpackage
`default_nettype wire

// ----- sv/mpi_cell.sv -----
// One iteration cell: a single z = z^2 + c step with escape and limit checks.
`default_nettype none
module mpi_cell
   import mpi_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic signed [QW-1:0] cr,
   input  wire logic signed [QW-1:0] ci,
   input  wire logic [ITER_W-1:0]    iter_limit,
   input  wire link_type             link_i,
   output link_type                  link_o
);
   link_type link_ff;
   link_type link_in;
   logic signed [2*QW-1:0] rr;
   logic signed [2*QW-1:0] ii;
   logic signed [2*QW-1:0] ri;
   logic [2*QW:0] mag;
   logic signed [2*QW:0] diff;
   logic signed [QW+3:0] nr_sum;
   logic signed [QW+3:0] ni_sum;
   logic signed [2*QW:0] dsh;
   logic signed [2*QW-1:0] rsh;

   always_comb begin
      rr = link_i.zr * link_i.zr;
      ii = link_i.zi * link_i.zi;
      ri = link_i.zr * link_i.zi;
      mag = {1'b0, rr} + {1'b0, ii};
      diff = (2*QW+1)'(rr) - (2*QW+1)'(ii);
      dsh = diff >>> FRAC_BITS;
      rsh = ri >>> (FRAC_BITS - 1);
      nr_sum = dsh[QW+3:0] + (QW+4)'(cr);
      ni_sum = rsh[QW+3:0] + (QW+4)'(ci);
      link_in = link_i;
      // An idle slot carries a zero count, so among the idle slots only a pixel that has just
      // finished shows a count in the ring.
      if (!link_i.active) begin
         link_in.count = '0;
      end else if (link_i.count >= iter_limit || mag >= ((2*QW+1)'(1) << 58)) begin
         link_in.active = 1'b0;
      end else begin
         link_in.zr = sat_q(nr_sum);
         link_in.zi = sat_q(ni_sum);
         link_in.count = link_i.count + ITER_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.active <= 1'b0;
      end else if (step) begin
         link_ff.active <= link_in.active;
      end
      if (step) begin
         link_ff.zr <= link_in.zr;
         link_ff.zi <= link_in.zi;
         link_ff.count <= link_in.count;
      end
   end

   assign link_o = link_ff;
endmodule
`default_nettype wire

// ----- sv/mandelbrot_pixel_iteration_unit.sv -----
// Top level of the Mandelbrot pixel iteration unit.
// The unit takes one pixel coordinate per transfer on the req_ channel and
// returns its escape-time count and color on the rsp_ channel.
// Configuration writes on the csr_ channel set the plane window and the
// iteration limit; they are always accepted and must be made while idle.
// One pixel is processed at a time. After acceptance, the ST_MAP_MUL and ST_MAP_ADD
// states map the coordinate onto the plane, then a ring of two iteration cells runs,
// the pixel making one complex step per cycle, until escape or the limit.
// The next request is accepted only once the result has moved into the output register.
// The result is held in an output register until the response transfer.
// While the receiver stalls, the next pixel is accepted and iterated, and
// it waits in the ring until the output register has been emptied.
// Reset clears control state and loads the default window and a limit of 25.
`default_nettype none
module mandelbrot_pixel_iteration_unit
   import mpi_pkg::*;
#(
   parameter int unsigned IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
   parameter int unsigned IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [COORD_W-1:0]   req_pixel_x,
   input  wire logic [COORD_W-1:0]   req_pixel_y,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [ITER_W-1:0]         rsp_iter_count,
   output logic [COLOR_W-1:0]        rsp_red,
   output logic [COLOR_W-1:0]        rsp_green,
   output logic [COLOR_W-1:0]        rsp_blue,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [QW-1:0]        csr_data
);
   localparam int unsigned XSH = $clog2(IMAGE_WIDTH);
   localparam int unsigned YSH = $clog2(IMAGE_HEIGHT);

   state_type state_ff, state_in;
   logic signed [QW-1:0] real_min_ff, real_max_ff, imag_min_ff, imag_max_ff;
   logic [ITER_W-1:0] iter_limit_ff;
   logic [COORD_W-1:0] px_ff, py_ff;
   logic signed [QW+COORD_W+1:0] xprod_ff, yprod_ff;
   logic signed [QW-1:0] cr_ff, ci_ff;
   logic signed [QW-1:0] cr_map, ci_map;
   logic [ITER_W-1:0] count_ff;
   logic [ITER_W-1:0] count_in;
   logic [ITER_W-1:0] ring_count;
   logic rsp_valid_ff;
   logic signed [QW+COORD_W+1:0] xq, yq;
   logic load, step, done, live, emit;
   link_type links [NUM_CELLS+1];
   link_type head;

   function automatic logic signed [QW-1:0] map_point(input logic signed [QW-1:0] lo,
         input logic signed [QW+COORD_W+1:0] q);
      logic signed [QW+COORD_W+2:0] s;
      logic signed [QW+COORD_W+2:0] hi_lim;
      logic signed [QW+COORD_W+2:0] lo_lim;
      s = (QW+COORD_W+3)'(lo) + (QW+COORD_W+3)'(q);
      hi_lim = (QW+COORD_W+3)'(signed'({1'b0, {(QW-1){1'b1}}}));
      lo_lim = -hi_lim - (QW+COORD_W+3)'(1);
      if (s > hi_lim) begin
         return hi_lim[QW-1:0];
      end else if (s < lo_lim) begin
         return lo_lim[QW-1:0];
      end
      return s[QW-1:0];
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         real_min_ff <= -32'sd402653184;
         real_max_ff <= 32'sd187904819;
         imag_min_ff <= -32'sd268435456;
         imag_max_ff <= 32'sd268435456;
         iter_limit_ff <= ITER_W'(25);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_REAL_MIN: real_min_ff <= csr_data;
            CSR_REAL_MAX: real_max_ff <= csr_data;
            CSR_IMAG_MIN: imag_min_ff <= csr_data;
            CSR_IMAG_MAX: imag_max_ff <= csr_data;
            CSR_ITER_LIMIT: iter_limit_ff <= csr_data[ITER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_MAP_MUL;
         ST_MAP_MUL: state_in = ST_MAP_ADD;
         ST_MAP_ADD: state_in = ST_ITER;
         ST_ITER:    if (done) state_in = ST_DONE;
         ST_DONE:    if (emit) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      load = (state_ff == ST_MAP_ADD);
      step = ((state_ff == ST_ITER) && !done) || load;
      emit = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      xq = xprod_ff >>> XSH;
      yq = yprod_ff >>> YSH;
      cr_map = map_point(real_min_ff, xq);
      ci_map = map_point(imag_min_ff, yq);
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         px_ff <= req_pixel_x;
         py_ff <= req_pixel_y;
      end
      if (state_ff == ST_MAP_MUL) begin
         xprod_ff <= $signed({1'b0, px_ff}) *
                     ((QW+COORD_W+2)'(real_max_ff) - (QW+COORD_W+2)'(real_min_ff));
         yprod_ff <= $signed({1'b0, py_ff}) *
                     ((QW+COORD_W+2)'(imag_max_ff) - (QW+COORD_W+2)'(imag_min_ff));
      end
      if (load) begin
         cr_ff <= cr_map;
         ci_ff <= ci_map;
      end
   end

   // The ring head injects a fresh z = 0 on load, else recirculates the tail.
   always_comb begin
      head = links[NUM_CELLS];
      if (load) begin
         head.active = 1'b1;
         head.zr = '0;
         head.zi = '0;
         head.count = '0;
      end
      links[0] = head;
   end

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      if (g == 0) begin : g_first
         mpi_cell u_cell (
            .clock(clock), .reset(reset), .step(step),
            .cr(load ? cr_map : cr_ff),
            .ci(load ? ci_map : ci_ff),
            .iter_limit(iter_limit_ff), .link_i(links[0]), .link_o(links[1])
         );
      end else begin : g_rest
         mpi_cell u_cell (
            .clock(clock), .reset(reset), .step(step),
            .cr(cr_ff), .ci(ci_ff), .iter_limit(iter_limit_ff),
            .link_i(links[g]), .link_o(links[g+1])
         );
      end
   end

   always_comb begin
      live = 1'b0;
      ring_count = '0;
      for (int k = 1; k <= NUM_CELLS; k++) begin
         live = live | links[k].active;
         ring_count = ring_count | links[k].count;
      end
   end

   assign done = !live;

   always_comb begin
      count_in = count_ff;
      if (emit) begin
         count_in = ring_count;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      rsp_valid = rsp_valid_ff;
      rsp_iter_count = count_ff;
      rsp_red = COLOR_W'(count_ff * count_ff);
      rsp_green = count_ff[COLOR_W-1:0];
      rsp_blue = count_ff[COLOR_W-1:0];
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_iter_count))
      else $error("response changed while stalled");
   a_done_before_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_DONE) else $error("bad done entry");
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_iter_count <= iter_limit_ff) else $error("count over limit");
endmodule
`default_nettype wire

// ----- tb/mandelbrot_pixel_iteration_unit_checker.sv -----
// Checker that predicts the escape-time result of each pixel and compares the responses.
module mandelbrot_pixel_iteration_unit_checker
   import mpi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [COORD_W-1:0]   req_pixel_x,
   input  logic [COORD_W-1:0]   req_pixel_y,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [ITER_W-1:0]    rsp_iter_count,
   input  logic [COLOR_W-1:0]   rsp_red,
   input  logic [COLOR_W-1:0]   rsp_green,
   input  logic [COLOR_W-1:0]   rsp_blue,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [QW-1:0]        csr_data,
   output int                   failures,
   output int                   pending
);
   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;

   longint win_re_lo, win_re_hi, win_im_lo, win_im_hi;
   int unsigned iter_limit;
   logic [ITER_W-1:0] expected_counts[$];

   function automatic longint clamp_q(longint v);
      if (v > QMAX) return QMAX;
      if (v < QMIN) return QMIN;
      return v;
   endfunction

   function automatic longint plane_point(int unsigned coord, longint lo, longint hi);
      longint prod;
      prod = longint'(coord) * (hi - lo);
      return clamp_q(lo + (prod >>> 8));
   endfunction

   function automatic logic [ITER_W-1:0] escape_count(int unsigned px, int unsigned py);
      longint cr, ci, zr, zi, rr, ii, ri;
      int unsigned n;
      cr = plane_point(px, win_re_lo, win_re_hi);
      ci = plane_point(py, win_im_lo, win_im_hi);
      zr = 0;
      zi = 0;
      n = 0;
      while (n < iter_limit) begin
         rr = zr * zr;
         ii = zi * zi;
         ri = zr * zi;
         if ((64'(unsigned'(rr)) + 64'(unsigned'(ii))) >= (64'd1 << 58)) break;
         zr = clamp_q(((rr - ii) >>> FRAC_BITS) + cr);
         zi = clamp_q((ri >>> (FRAC_BITS - 1)) + ci);
         n++;
      end
      return n[ITER_W-1:0];
   endfunction

   assign pending = expected_counts.size();

   always @(posedge clock) begin
      logic [ITER_W-1:0] n;
      logic [15:0] sq;
      if (reset) begin
         win_re_lo <= -402653184;
         win_re_hi <= 187904819;
         win_im_lo <= -268435456;
         win_im_hi <= 268435456;
         iter_limit <= 25;
         expected_counts.delete();
         failures <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_REAL_MIN: win_re_lo <= longint'(signed'(csr_data));
               CSR_REAL_MAX: win_re_hi <= longint'(signed'(csr_data));
               CSR_IMAG_MIN: win_im_lo <= longint'(signed'(csr_data));
               CSR_IMAG_MAX: win_im_hi <= longint'(signed'(csr_data));
               CSR_ITER_LIMIT: iter_limit <= {22'd0, csr_data[ITER_W-1:0]};
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_counts.push_back(escape_count(req_pixel_x, req_pixel_y));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               $error("unexpected response transfer, iter_count %0d", rsp_iter_count);
               failures <= failures + 1;
            end else begin
               n = expected_counts.pop_front();
               sq = n * n;
               if (rsp_iter_count !== n || rsp_red !== sq[7:0] || rsp_green !== n[7:0]
                   || rsp_blue !== n[7:0]) begin
                  failures <= failures + 1;
                  if (rsp_iter_count !== n)
                     $error("iter_count expected %0d actual %0d", n, rsp_iter_count);
                  if (rsp_red !== sq[7:0])
                     $error("red expected %0d actual %0d", sq[7:0], rsp_red);
                  if (rsp_green !== n[7:0])
                     $error("green expected %0d actual %0d", n[7:0], rsp_green);
                  if (rsp_blue !== n[7:0])
                     $error("blue expected %0d actual %0d", n[7:0], rsp_blue);
               end
            end
         end
      end
   end
endmodule

// ----- tb/mandelbrot_pixel_iteration_unit_test.sv -----
// Testbench top that drives pixels and window settings into the unit and reports the verdict.
module mandelbrot_pixel_iteration_unit_test;
   import mpi_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [COORD_W-1:0]   req_pixel_x;
   logic [COORD_W-1:0]   req_pixel_y;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [ITER_W-1:0]    rsp_iter_count;
   logic [COLOR_W-1:0]   rsp_red;
   logic [COLOR_W-1:0]   rsp_green;
   logic [COLOR_W-1:0]   rsp_blue;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [QW-1:0]        csr_data;
   int                   failures;
   int                   pending;
   int                   send_idle_pct;
   int                   recv_stall_pct;

   mandelbrot_pixel_iteration_unit dut (.*);

   mandelbrot_pixel_iteration_unit_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Valid stays high after the transfer; the caller lowers it once the burst ends.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [QW-1:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic send_pixel(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_pixel_x <= px;
      req_pixel_y <= py;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_window(int lo_re, int hi_re, int lo_im, int hi_im, int limit);
      write_csr(CSR_REAL_MIN, lo_re);
      write_csr(CSR_REAL_MAX, hi_re);
      write_csr(CSR_IMAG_MIN, lo_im);
      write_csr(CSR_IMAG_MAX, hi_im);
      write_csr(CSR_ITER_LIMIT, limit);
      csr_valid <= 0;
   endtask

   initial begin
      int phase;
      int limit;
      reset = 1;
      req_valid = 0;
      req_pixel_x = 0;
      req_pixel_y = 0;
      rsp_ready = 0;
      csr_valid = 0;
      csr_index = 0;
      csr_data = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_pixel(0, 0);
      send_pixel(255, 255);
      send_pixel(0, 255);
      send_pixel(255, 0);
      send_pixel(128, 128);
      send_pixel(85, 170);
      drain();
      set_window(-402653184, 187904819, -268435456, 268435456, 0);
      send_pixel(200, 100);
      drain();
      set_window(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1023);
      send_pixel(0, 0);
      send_pixel(255, 255);
      send_pixel(128, 128);
      send_pixel(127, 129);
      drain();
      set_window(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1);
      send_pixel(0, 255);
      send_pixel(255, 0);
      send_pixel(128, 128);
      drain();
      set_window(-100000000, -100000000, 50000000, 50000000, 1023);
      send_pixel(3, 7);
      drain();

      for (phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         limit = (phase == 7) ? 1023 : int'($urandom_range(60));
         if (phase == 0)
            set_window(-402653184, 187904819, -268435456, 268435456, 25);
         else
            set_window(-int'($urandom_range(700000000)), int'($urandom_range(300000000)),
                       -int'($urandom_range(400000000)), int'($urandom_range(400000000)),
                       limit);
         repeat (phase == 7 ? 30 : 125) begin
            if ($urandom_range(9) == 0)
               send_pixel(COORD_W'($urandom_range(1) * 255),
                          COORD_W'($urandom_range(1) * 255));
            else
               send_pixel(COORD_W'($urandom), COORD_W'($urandom));
         end
         drain();
      end
      recv_stall_pct = 0;
      drain();
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

// ----- filelist.f -----
sv/mpi_pkg.sv
sv/mpi_cell.sv
sv/mandelbrot_pixel_iteration_unit.sv
tb/mandelbrot_pixel_iteration_unit_checker.sv
tb/mandelbrot_pixel_iteration_unit_test.sv
